// File: hdl/tfs_pkg.sv
// shared types and constants for the telemetry frame serializer
`default_nettype none
package tfs_pkg;

  localparam int FRAME_MAX  = 24;
  localparam int WORDS_MAX  = 9;
  localparam int ATT_WORDS  = 6;
  localparam int SNS_WORDS  = 9;

  localparam logic [7:0] SYNC0      = 8'hA5;
  localparam logic [7:0] SYNC1      = 8'h5A;
  localparam logic [7:0] TAIL_BYTE  = 8'hAA;
  localparam logic [7:0] ATT_LEN    = 8'd16;
  localparam logic [7:0] SNS_LEN    = 8'd22;
  localparam logic [7:0] ATT_TYPE   = 8'hA1;
  localparam logic [7:0] SNS_TYPE   = 8'hA2;
  localparam logic [15:0] SM_OFFSET = 16'h8000;

  // role of a byte as it leaves the chain
  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_SUM   = 2'd1,
    KIND_CSUM  = 2'd2,
    KIND_TAIL  = 2'd3
  } kind_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
  } cell_t;

  // two's complement to sign-magnitude, most negative value wraps to zero
  function automatic logic [15:0] to_sm(input logic [15:0] w);
    logic [15:0] r;
    r = w;
    if (w[15]) begin
      r = SM_OFFSET - w;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/tfs_cell.sv
// one byte cell of the shift chain
`default_nettype none
module tfs_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 load,
  input  wire                 advance,
  input  wire tfs_pkg::cell_t load_val,
  input  wire tfs_pkg::cell_t shift_in,
  output tfs_pkg::cell_t      q
);
  import tfs_pkg::*;

  // load a fresh frame byte or take the neighbour's byte
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (load) begin
      q <= load_val;
    end else if (advance) begin
      q <= shift_in;
    end
  end

endmodule
`default_nettype wire

// File: hdl/tfs_head.sv
// output end of the chain with running checksum
`default_nettype none
module tfs_head (
  input  wire                 clk,
  input  wire                 rst,
  input  wire tfs_pkg::cell_t head,
  input  wire                 out_stall,
  output logic                out_valid,
  output logic [7:0]          tx_byte,
  output logic                frame_end
);
  import tfs_pkg::*;

  logic [7:0] acc;
  logic       take;

  assign take      = head.valid && !out_stall;
  assign out_valid = head.valid;
  assign tx_byte   = (head.kind == KIND_CSUM) ? acc : head.data;
  assign frame_end = (head.kind == KIND_TAIL);

  // sum of length, type and payload bytes, cleared once sent
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 8'd0;
    end else if (take) begin
      if (head.kind == KIND_SUM) begin
        acc <= acc + head.data;
      end else if (head.kind == KIND_CSUM) begin
        acc <= 8'd0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/telemetry_frame_serializer.sv
// top level: frame builder feeding a chain of byte cells
// first byte: the first byte of a frame is shown in the cycle after its item is accepted
// throughput: one byte per cycle while out_stall is low; an attitude frame is 18 bytes and a sensor frame 24,
// held in the 24-cell byte chain, which takes the next item as the last byte of a frame leaves
// reset: clears the valid bit of every cell and the checksum accumulator
`default_nettype none
module telemetry_frame_serializer (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               req_type,
  input  wire signed [15:0] word_0,
  input  wire signed [15:0] word_1,
  input  wire signed [15:0] word_2,
  input  wire signed [15:0] word_3,
  input  wire signed [15:0] word_4,
  input  wire signed [15:0] word_5,
  input  wire signed [15:0] word_6,
  input  wire signed [15:0] word_7,
  input  wire signed [15:0] word_8,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [7:0]        tx_byte,
  output logic              frame_end
);
  import tfs_pkg::*;

  cell_t       cells    [FRAME_MAX];
  cell_t       load_val [FRAME_MAX];
  cell_t       empty_cell;
  logic [15:0] words    [WORDS_MAX];
  logic [15:0] sm;
  logic        tail_busy;
  logic        advance;
  logic        load;

  assign words[0] = word_0;
  assign words[1] = word_1;
  assign words[2] = word_2;
  assign words[3] = word_3;
  assign words[4] = word_4;
  assign words[5] = word_5;
  assign words[6] = word_6;
  assign words[7] = word_7;
  assign words[8] = word_8;

  assign empty_cell = '{valid: 1'b0, kind: KIND_PLAIN, data: 8'd0};

  // any byte still queued behind the head
  always_comb begin
    tail_busy = 1'b0;
    for (int i = 1; i < FRAME_MAX; i++) begin
      tail_busy = tail_busy | cells[i].valid;
    end
  end

  assign advance  = !cells[0].valid || !out_stall;
  assign in_stall = tail_busy || !advance;
  assign load     = in_valid && !in_stall;

  // lay out the whole frame over the cells
  always_comb begin
    sm = 16'd0;
    for (int i = 0; i < FRAME_MAX; i++) begin
      load_val[i] = empty_cell;
    end
    load_val[0] = '{valid: 1'b1, kind: KIND_PLAIN, data: SYNC0};
    load_val[1] = '{valid: 1'b1, kind: KIND_PLAIN, data: SYNC1};
    load_val[2] = '{valid: 1'b1, kind: KIND_SUM, data: req_type ? SNS_LEN : ATT_LEN};
    load_val[3] = '{valid: 1'b1, kind: KIND_SUM, data: req_type ? SNS_TYPE : ATT_TYPE};
    for (int i = 0; i < WORDS_MAX; i++) begin
      sm = to_sm(words[i]);
      if (i < ATT_WORDS || req_type) begin
        load_val[4 + 2 * i] = '{valid: 1'b1, kind: KIND_SUM, data: sm[15:8]};
        load_val[5 + 2 * i] = '{valid: 1'b1, kind: KIND_SUM, data: sm[7:0]};
      end
    end
    if (req_type) begin
      load_val[4 + 2 * SNS_WORDS] = '{valid: 1'b1, kind: KIND_CSUM, data: 8'd0};
      load_val[5 + 2 * SNS_WORDS] = '{valid: 1'b1, kind: KIND_TAIL, data: TAIL_BYTE};
    end else begin
      load_val[4 + 2 * ATT_WORDS] = '{valid: 1'b1, kind: KIND_CSUM, data: 8'd0};
      load_val[5 + 2 * ATT_WORDS] = '{valid: 1'b1, kind: KIND_TAIL, data: TAIL_BYTE};
    end
  end

  // byte chain, moving towards cell zero
  for (genvar g = 0; g < FRAME_MAX; g++) begin : g_cell
    if (g == FRAME_MAX - 1) begin : g_last
      tfs_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .load     (load),
        .advance  (advance),
        .load_val (load_val[g]),
        .shift_in (empty_cell),
        .q        (cells[g])
      );
    end else begin : g_mid
      tfs_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .load     (load),
        .advance  (advance),
        .load_val (load_val[g]),
        .shift_in (cells[g + 1]),
        .q        (cells[g])
      );
    end
  end

  // output end and checksum
  tfs_head u_head (
    .clk       (clk),
    .rst       (rst),
    .head      (cells[0]),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .tx_byte   (tx_byte),
    .frame_end (frame_end)
  );

endmodule
`default_nettype wire

// File: dv/telemetry_frame_serializer_test.sv
// self-checking testbench for the telemetry frame serializer
`default_nettype none
module telemetry_frame_serializer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tfs_pkg::*;

  localparam logic REQ_ATTITUDE    = 1'b0;
  localparam logic REQ_SENSOR      = 1'b1;
  localparam int   RANDOM_PER_PHASE = 125;
  localparam int   DRAIN_CYCLES     = 30;
  localparam int   WATCHDOG_LIMIT   = 2000;

  typedef struct {
    logic [7:0] tx_byte;
    logic       frame_end;
  } frame_byte_t;

  // frame predictor and byte queue
  class frame_checker;
    frame_byte_t expected_bytes[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    // two's complement to sign-magnitude; the most negative value wraps to zero
    function logic [15:0] sign_magnitude(logic [15:0] w);
      logic [15:0] mag;
      mag = ~w + 16'd1;
      if (w[15]) begin
        return 16'h8000 + mag;
      end
      return w;
    endfunction

    function void push_byte(logic [7:0] b, logic last);
      frame_byte_t fb;
      fb.tx_byte   = b;
      fb.frame_end = last;
      expected_bytes.push_back(fb);
    endfunction

    // build the whole frame for one accepted request
    function void note_request(logic req_type, logic [8:0][15:0] words);
      logic [7:0]  len_code;
      logic [7:0]  type_code;
      logic [7:0]  checksum;
      logic [15:0] sm;
      int          n_words;
      len_code  = (req_type == REQ_SENSOR) ? SNS_LEN : ATT_LEN;
      type_code = (req_type == REQ_SENSOR) ? SNS_TYPE : ATT_TYPE;
      n_words   = (req_type == REQ_SENSOR) ? SNS_WORDS : ATT_WORDS;
      checksum  = len_code + type_code;
      push_byte(SYNC0, 1'b0);
      push_byte(SYNC1, 1'b0);
      push_byte(len_code, 1'b0);
      push_byte(type_code, 1'b0);
      for (int i = 0; i < n_words; i++) begin
        sm = sign_magnitude(words[i]);
        push_byte(sm[15:8], 1'b0);
        push_byte(sm[7:0], 1'b0);
        checksum = checksum + sm[15:8] + sm[7:0];
      end
      push_byte(checksum, 1'b0);
      push_byte(TAIL_BYTE, 1'b1);
    endfunction

    // compare one emitted byte against the oldest expectation
    function void check_byte(logic [7:0] tx, logic fe);
      frame_byte_t fb;
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte: tx_byte %h frame_end %b", tx, fe);
        errors++;
        return;
      end
      fb = expected_bytes.pop_front();
      if (tx !== fb.tx_byte) begin
        $error("tx_byte: expected %h, got %h", fb.tx_byte, tx);
        errors++;
      end
      if (fe !== fb.frame_end) begin
        $error("frame_end: expected %b, got %b", fb.frame_end, fe);
        errors++;
      end
    endfunction

    function int pending_count();
      return expected_bytes.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              req_type;
  logic signed [15:0] word_0, word_1, word_2, word_3, word_4;
  logic signed [15:0] word_5, word_6, word_7, word_8;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        tx_byte;
  logic              frame_end;

  frame_checker sb;
  int           send_idle_pct;
  int           stall_pct;
  int           quiet_cycles;

  telemetry_frame_serializer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .word_0    (word_0),
    .word_1    (word_1),
    .word_2    (word_2),
    .word_3    (word_3),
    .word_4    (word_4),
    .word_5    (word_5),
    .word_6    (word_6),
    .word_7    (word_7),
    .word_8    (word_8),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_byte   (tx_byte),
    .frame_end (frame_end)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // record accepted requests
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sb.note_request(req_type, {word_8, word_7, word_6, word_5, word_4,
                                 word_3, word_2, word_1, word_0});
    end
  end

  // check emitted bytes
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_byte(tx_byte, frame_end);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // drive one request, called and returning at a falling edge
  task automatic send_request(input logic rt, input logic [8:0][15:0] w);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    word_0   <= w[0];
    word_1   <= w[1];
    word_2   <= w[2];
    word_3   <= w[3];
    word_4   <= w[4];
    word_5   <= w[5];
    word_6   <= w[6];
    word_7   <= w[7];
    word_8   <= w[8];
    do begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end while (!taken);
  endtask

  // value mix biased towards the sign-magnitude corners
  function automatic logic [15:0] random_word();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      5: return 16'h8001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [8:0][15:0] fill_words(logic [15:0] v);
    logic [8:0][15:0] w;
    for (int i = 0; i < 9; i++) begin
      w[i] = v;
    end
    return w;
  endfunction

  // stimulus
  initial begin
    logic [8:0][15:0] w;
    sb            = new();
    send_idle_pct = 0;
    stall_pct     = 0;
    quiet_cycles  = 0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    out_stall     = 1'b0;
    req_type      = REQ_ATTITUDE;
    word_0 = '0; word_1 = '0; word_2 = '0; word_3 = '0; word_4 = '0;
    word_5 = '0; word_6 = '0; word_7 = '0; word_8 = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: zero, most negative and most positive in both frames, minus one in a sensor frame
    send_request(REQ_ATTITUDE, fill_words(16'h0000));
    send_request(REQ_SENSOR, fill_words(16'h0000));
    send_request(REQ_ATTITUDE, fill_words(16'h8000));
    send_request(REQ_SENSOR, fill_words(16'h8000));
    send_request(REQ_ATTITUDE, fill_words(16'h7FFF));
    send_request(REQ_SENSOR, fill_words(16'h7FFF));
    send_request(REQ_SENSOR, fill_words(16'hFFFF));
    // unused words in the attitude frame carry junk
    w = fill_words(16'h0001);
    w[6] = 16'hFFFF; w[7] = 16'h8000; w[8] = 16'h7FFF;
    send_request(REQ_ATTITUDE, w);
    w[0] = 16'h8001; w[1] = 16'h7FFF; w[2] = 16'h8000; w[3] = 16'h0000;
    w[4] = 16'hFFFF; w[5] = 16'h0001; w[6] = 16'h1234; w[7] = 16'hEDCC;
    w[8] = 16'h5555;
    send_request(REQ_SENSOR, w);
    w = fill_words(16'h5555);
    w[1] = 16'hAAAA; w[3] = 16'hAAAA; w[5] = 16'hAAAA; w[7] = 16'hAAAA;
    send_request(REQ_ATTITUDE, w);
    send_request(REQ_SENSOR, w);
    send_request(REQ_SENSOR, ~w);
    w = fill_words(16'hFFFE);
    w[1] = 16'h0002;
    send_request(REQ_ATTITUDE, w);

    // random requests across the idle and stall phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 48; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        for (int i = 0; i < 9; i++) begin
          w[i] = random_word();
        end
        send_request(logic'($urandom_range(0, 1)), w);
      end
    end
    in_valid <= 1'b0;

    // drain and settle
    while (sb.pending_count() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
